// ===== design/bilrs_pkg.sv =====
`default_nettype none
package bilrs_pkg;

  localparam int unsigned MaxWidth   = 256;
  localparam int unsigned MaxHeight  = 256;
  localparam int unsigned DimW       = 9;
  localparam int unsigned CoordW     = 8;
  localparam int unsigned IdxW       = 16;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned NumChan    = 3;
  localparam int unsigned PixW       = ChanW * NumChan;
  localparam int unsigned FracW      = 16;
  localparam int unsigned RatioW     = CoordW + FracW;
  localparam int unsigned PosW       = CoordW + RatioW;
  localparam int unsigned RowW       = CoordW + DimW;
  localparam int unsigned WeightW    = 2 * FracW + 1;
  localparam int unsigned AccW       = WeightW + ChanW - 1;
  localparam int unsigned StoreDepth = 1 << IdxW;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned NumTaps    = 4;
  localparam int unsigned InDataW    = IdxW + PixW + 2 * CoordW;

  typedef enum logic {
    OpLoad     = 1'b0,
    OpResample = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegSrcWidth  = 2'd0,
    RegSrcHeight = 2'd1,
    RegDstWidth  = 2'd2,
    RegDstHeight = 2'd3
  } cfg_reg_e;

  // one frame store read travelling to the channel lanes
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic [WeightW-1:0] weight;
  } rd_tag_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] mx);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (v > mx) r = mx;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/bilrs_ram.sv =====
`default_nettype none
module bilrs_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// ===== design/bilrs_div.sv =====
`default_nettype none
module bilrs_div import bilrs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [RatioW-1:0] dividend_i,
  input  wire logic [CoordW-1:0] divisor_i,
  output logic                   busy_o,
  output logic      [RatioW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(RatioW);

  logic              busy_q, busy_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CoordW-1:0] rem_q, rem_d, div_q, div_d;
  logic [RatioW-1:0] quo_q, quo_d;
  logic [CoordW:0]   trial;

  // restoring division, one quotient bit a cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[RatioW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(RatioW - 1);
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = CoordW'(trial - {1'b0, div_q});
        quo_d = {quo_q[RatioW-2:0], 1'b1};
      end else begin
        rem_d = trial[CoordW-1:0];
        quo_d = {quo_q[RatioW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

// ===== design/bilrs_lane.sv =====
`default_nettype none
module bilrs_lane import bilrs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rd_tag_t          tag_i,
  input  wire logic [ChanW-1:0] pix_i,
  output logic                  done_o,
  output logic      [ChanW-1:0] chan_o
);

  logic [AccW-1:0] acc_q, acc_d, prod;
  logic            done_q;

  // one tap a cycle while the tag is valid: weighted pixel added into the Q32 sum
  always_comb begin
    prod  = AccW'({{(WeightW){1'b0}}, pix_i} * {{(ChanW){1'b0}}, tag_i.weight});
    acc_d = (tag_i.first ? '0 : acc_q) + prod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= tag_i.valid && tag_i.last;
  end

  always_ff @(posedge clk_i) begin
    if (tag_i.valid) acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign chan_o = acc_q[AccW-1 -: ChanW];

endmodule
`default_nettype wire

// ===== design/bilinear_rgb_resampler_top.sv =====
`default_nettype none
// bilinear rgb resampler: a load word (tuser 0) writes one 24-bit pixel into a 64k-entry frame
// store and gives no result; a resample word (tuser 1) names a destination pixel and gives one
// blended pixel. a resample takes one read of the single frame store port per neighbor tap,
// so the port serves one resample's four taps in turn, and loads run at one per cycle when
// nothing stalls; new words are accepted before earlier results are out. after reset and
// after every configuration write the two scale ratios are recomputed by serial dividers
// (a start, then 24 quotient steps, while tready is held low). the three channels are
// blended in three lanes side by side and merged into a two-word output buffer.
module bilinear_rgb_resampler_top import bilrs_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [DimW-1:0]     cfg_data_i,
  // input words
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // pixel_index, in_chan0, in_chan1, in_chan2, dest_x, dest_y
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // opcode
  input  wire logic                s_axis_tuser,
  // result words
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // out_chan0, out_chan1, out_chan2
  output logic      [PixW-1:0]     m_axis_tdata
);

  localparam logic [DimW-1:0] MaxW = DimW'(MaxWidth);
  localparam logic [DimW-1:0] MaxH = DimW'(MaxHeight);
  localparam logic [FracW:0]  One  = (FracW+1)'(1) << FracW;

  // configuration registers
  logic [DimW-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [DimW-1:0] sw, sh, tw, th;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DimW'(256);
      src_h_q <= DimW'(256);
      dst_w_q <= DimW'(96);
      dst_h_q <= DimW'(96);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegSrcWidth:  src_w_q <= cfg_data_i;
        RegSrcHeight: src_h_q <= cfg_data_i;
        RegDstWidth:  dst_w_q <= cfg_data_i;
        RegDstHeight: dst_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sw = clamp_dim(src_w_q, MaxW);
  assign sh = clamp_dim(src_h_q, MaxH);
  assign tw = clamp_dim(dst_w_q, MaxW);
  assign th = clamp_dim(dst_h_q, MaxH);

  // ratio recompute: dirty after reset and after any write
  logic              dirty_q, div_start, busy_x, busy_y, ratio_ok;
  logic [RatioW-1:0] quot_x, quot_y, ratio_x, ratio_y;
  logic [DimW-1:0]   sw_m1, sh_m1, tw_m1, th_m1;

  assign sw_m1 = sw - DimW'(1);
  assign sh_m1 = sh - DimW'(1);
  assign tw_m1 = tw - DimW'(1);
  assign th_m1 = th - DimW'(1);

  assign div_start = dirty_q && !busy_x;
  assign ratio_ok  = !dirty_q && !busy_x && !busy_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       dirty_q <= 1'b1;
    else if (cfg_we_i) dirty_q <= 1'b1;
    else if (div_start) dirty_q <= 1'b0;
  end

  bilrs_div u_div_x (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i({sw_m1[CoordW-1:0], {FracW{1'b0}}}),
    .divisor_i(tw_m1[CoordW-1:0]), .busy_o(busy_x), .quot_o(quot_x)
  );

  bilrs_div u_div_y (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i({sh_m1[CoordW-1:0], {FracW{1'b0}}}),
    .divisor_i(th_m1[CoordW-1:0]), .busy_o(busy_y), .quot_o(quot_y)
  );

  // a destination size of one maps everything to column or row zero
  assign ratio_x = (tw_m1 == '0) ? '0 : quot_x;
  assign ratio_y = (th_m1 == '0) ? '0 : quot_y;

  // input unpacking
  logic [IdxW-1:0]   in_idx;
  logic [PixW-1:0]   in_pix;
  logic [CoordW-1:0] in_dx, in_dy;
  assign in_idx = s_axis_tdata[IdxW-1:0];
  assign in_pix = s_axis_tdata[IdxW +: PixW];
  assign in_dx  = s_axis_tdata[IdxW+PixW +: CoordW];
  assign in_dy  = s_axis_tdata[IdxW+PixW+CoordW +: CoordW];

  // pipeline handshake
  logic m_valid_q, p_valid_q, q_valid_q;
  logic m_ready, p_ready, q_ready, q_done, go, in_acc;
  opcode_e m_op_q, p_op_q, q_op_q;

  // map stage: source position in Q16
  logic [IdxW-1:0] m_idx_q;
  logic [PixW-1:0] m_pix_q;
  logic [PosW-1:0] m_sx_q, m_sy_q;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = m_ready && ratio_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)      m_valid_q <= 1'b0;
    else if (m_ready) m_valid_q <= in_acc;
  end

  always_ff @(posedge clk_i) begin
    if (m_ready) begin
      m_op_q  <= opcode_e'(s_axis_tuser);
      m_idx_q <= in_idx;
      m_pix_q <= in_pix;
      m_sx_q  <= PosW'(in_dx) * PosW'(ratio_x);
      m_sy_q  <= PosW'(in_dy) * PosW'(ratio_y);
    end
  end

  // prep stage: edge clamp, neighbors and row bases
  logic [CoordW-1:0] x1, x2, y1, y2;
  logic [FracW-1:0]  bx, by;
  logic [CoordW:0]   x1p, y1p;
  logic              clamp_x, clamp_y;
  logic [IdxW-1:0]   p_idx_q;
  logic [PixW-1:0]   p_pix_q;
  logic [CoordW-1:0] p_x1_q, p_x2_q;
  logic [RowW-1:0]   p_row1_q, p_row2_q;
  logic [FracW-1:0]  p_bx_q, p_by_q;

  always_comb begin
    clamp_x = m_sx_q[PosW-1:FracW] >= (PosW-FracW)'(sw_m1);
    clamp_y = m_sy_q[PosW-1:FracW] >= (PosW-FracW)'(sh_m1);
    x1  = clamp_x ? sw_m1[CoordW-1:0] : m_sx_q[FracW +: CoordW];
    y1  = clamp_y ? sh_m1[CoordW-1:0] : m_sy_q[FracW +: CoordW];
    bx  = clamp_x ? '0 : m_sx_q[FracW-1:0];
    by  = clamp_y ? '0 : m_sy_q[FracW-1:0];
    x1p = {1'b0, x1} + (CoordW+1)'(1);
    y1p = {1'b0, y1} + (CoordW+1)'(1);
    x2  = (x1p < sw) ? x1p[CoordW-1:0] : sw_m1[CoordW-1:0];
    y2  = (y1p < sh) ? y1p[CoordW-1:0] : sh_m1[CoordW-1:0];
  end

  assign p_ready = !p_valid_q || q_ready;
  assign m_ready = !m_valid_q || p_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)      p_valid_q <= 1'b0;
    else if (p_ready) p_valid_q <= m_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (p_ready) begin
      p_op_q   <= m_op_q;
      p_idx_q  <= m_idx_q;
      p_pix_q  <= m_pix_q;
      p_x1_q   <= x1;
      p_x2_q   <= x2;
      p_row1_q <= RowW'(y1) * RowW'(sw);
      p_row2_q <= RowW'(y2) * RowW'(sw);
      p_bx_q   <= bx;
      p_by_q   <= by;
    end
  end

  // job stage: four tap addresses and weights for the read sequencer
  logic [FracW:0]     ax, ay;
  logic [IdxW-1:0]    q_addr_q [NumTaps];
  logic [WeightW-1:0] q_w_q    [NumTaps];
  logic [PixW-1:0]    q_pix_q;
  logic [1:0]         cnt_q;

  assign ax = One - {1'b0, p_bx_q};
  assign ay = One - {1'b0, p_by_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)      q_valid_q <= 1'b0;
    else if (q_ready) q_valid_q <= p_valid_q;
  end

  // weights need the full 33 bits: both ones give exactly 2^32
  always_ff @(posedge clk_i) begin
    if (q_ready) begin
      q_op_q      <= p_op_q;
      q_pix_q     <= p_pix_q;
      // a load carries its store index in the first tap
      q_addr_q[0] <= (p_op_q == OpLoad) ? p_idx_q : IdxW'(p_row1_q + RowW'(p_x1_q));
      q_addr_q[1] <= IdxW'(p_row1_q + RowW'(p_x2_q));
      q_addr_q[2] <= IdxW'(p_row2_q + RowW'(p_x1_q));
      q_addr_q[3] <= IdxW'(p_row2_q + RowW'(p_x2_q));
      q_w_q[0]    <= WeightW'(ax) * WeightW'(ay);
      q_w_q[1]    <= WeightW'(p_bx_q) * WeightW'(ay);
      q_w_q[2]    <= WeightW'(ax) * WeightW'(p_by_q);
      q_w_q[3]    <= WeightW'(p_bx_q) * WeightW'(p_by_q);
    end
  end

  // read sequencer: a resample reserves an output slot when it issues its first tap
  logic [1:0] credits_q, credits_d;
  logic       out_acc, reserve;

  assign go      = q_valid_q && (q_op_q == OpLoad || cnt_q != '0 || credits_q < 2'd2);
  assign q_done  = go && (q_op_q == OpLoad || cnt_q == 2'd3);
  assign q_ready = !q_valid_q || q_done;
  assign reserve = go && q_op_q == OpResample && cnt_q == '0;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    credits_d = credits_q;
    if (reserve && !out_acc)      credits_d = credits_q + 2'd1;
    else if (!reserve && out_acc) credits_d = credits_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      credits_q <= '0;
    end else begin
      if (go && q_op_q == OpResample) cnt_q <= cnt_q + 2'd1;
      credits_q <= credits_d;
    end
  end

  // frame store
  logic            ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [PixW-1:0] ram_rdata;

  assign ram_we   = go && q_op_q == OpLoad;
  assign ram_addr = (q_op_q == OpLoad) ? q_addr_q[0] : q_addr_q[cnt_q];

  bilrs_ram #(.Width(PixW), .Depth(StoreDepth)) u_store (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(q_pix_q), .rdata_o(ram_rdata)
  );

  // tag is registered alongside the read, so it reaches the lanes with the read data
  logic               tag_valid_q, tag_first_q, tag_last_q;
  logic [WeightW-1:0] tag_w_q;
  rd_tag_t            rd_tag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tag_valid_q <= 1'b0;
    else         tag_valid_q <= go && q_op_q == OpResample;
  end

  always_ff @(posedge clk_i) begin
    tag_first_q <= cnt_q == 2'd0;
    tag_last_q  <= cnt_q == 2'd3;
    tag_w_q     <= q_w_q[cnt_q];
  end

  assign rd_tag = '{valid: tag_valid_q, first: tag_first_q, last: tag_last_q,
                    weight: tag_w_q};

  // channel lanes
  logic [NumChan-1:0] lane_done;
  logic [PixW-1:0]    res_pix;

  for (genvar c = 0; c < NumChan; c++) begin : g_lane
    bilrs_lane u_lane (
      .clk_i, .rst_ni, .tag_i(rd_tag),
      .pix_i(ram_rdata[c*ChanW +: ChanW]),
      .done_o(lane_done[c]), .chan_o(res_pix[c*ChanW +: ChanW])
    );
  end

  // merge: two-word output buffer
  logic [PixW-1:0] buf_q [2];
  logic            wptr_q, rptr_q, push;
  logic [1:0]      fill_q;

  assign push = lane_done[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= '0;
    end else begin
      if (push)    wptr_q <= !wptr_q;
      if (out_acc) rptr_q <= !rptr_q;
      if (push && !out_acc)      fill_q <= fill_q + 2'd1;
      else if (!push && out_acc) fill_q <= fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wptr_q] <= res_pix;
  end

  assign m_axis_tvalid = fill_q != '0;
  assign m_axis_tdata  = buf_q[rptr_q];

  // checks
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credits_q <= 2'd2) else $error("output slot reservations exceed buffer");
  a_fill_le_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= credits_q) else $error("buffered results exceed reservations");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fill_q < 2'd2 || out_acc)) else $error("output buffer overflow");
  a_ready_ratio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!dirty_q && !busy_x && !busy_y)) else $error("accept during ratio update");
  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_done[0] == lane_done[NumChan-1]) else $error("lanes out of step");

endmodule
`default_nettype wire
